// File: hw/rtl/xset_pkg.sv
// Package for the XML event tokenizer: phase, event and error codes,
// controller/datapath command and status types. No dependencies.
`default_nettype none
package xset_pkg;

	typedef enum logic [4:0] {
		PH_SKIP, PH_DOC, PH_DOC_LT, PH_PI, PH_PI_Q, PH_CMT, PH_CMT_D1, PH_CMT_D2,
		PH_STAG, PH_STAG_SL, PH_STAG_WS, PH_ANAME, PH_AEQ, PH_AVAL,
		PH_CONTENT, PH_CONTENT_LT, PH_ETAG, PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		EV_STARTDOC = 4'd0, EV_PI_BYTE = 4'd1, EV_PI_END = 4'd2, EV_NAME_BYTE = 4'd3,
		EV_ATTR_NAME = 4'd4, EV_ATTR_VALUE = 4'd5, EV_ATTR_END = 4'd6,
		EV_START_ELEM = 4'd7, EV_END_ELEM = 4'd8, EV_TEXT_BYTE = 4'd9,
		EV_TEXT_END = 4'd10, EV_ENDDOC = 4'd11, EV_ERROR = 4'd12
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0, ERR_BAD_START = 3'd1, ERR_BAD_PI_END = 3'd2,
		ERR_BAD_ELEM_END = 3'd3, ERR_BAD_QUOTE = 3'd4, ERR_PREMATURE = 3'd5,
		ERR_UNDERFLOW = 3'd6, ERR_OVERFLOW = 3'd7
	} err_t;

	// Sequencer states: idle, emit the queued list, then flush held spaces.
	typedef enum logic [1:0] {
		ST_IDLE, ST_EMIT, ST_FLUSH
	} ctl_state_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int EVQ = 5; // planned events per byte, flush excluded

	typedef struct packed {
		event_t      ev;
		logic        use_byte;
		err_t        err;
	} plan_ev_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // item accepted: decode and plan
		logic advance;    // output slot taken: go to next planned event
		logic flush_step; // output slot taken during flush
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_plan;   // a planned event of the byte is still to be sent
		logic plan_last;  // current planned event is the final planned one
		logic flush_req;  // a flush follows the plan
		logic flush_last; // current flush entry is the final one
	} dp_sts_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
			c == 8'h0C || c == 8'h0D;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/xset_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module xset_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/xset_ctl.sv
// Controller: input/output handshake and event sequencing.
// Depends on xset_pkg.
`default_nettype none
module xset_ctl import xset_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output logic         out_last,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);
	ctl_state_t state_q, state_d;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign take = out_valid && out_ready;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = sts.has_plan;
				out_last  = sts.plan_last && !sts.flush_req;
				if (!sts.has_plan) begin
					state_d = sts.flush_req ? ST_FLUSH : ST_IDLE;
				end else if (take) begin
					cmd.advance = 1'b1;
					if (sts.plan_last) state_d = sts.flush_req ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				out_valid = 1'b1;
				out_last  = sts.flush_last;
				if (take) begin
					cmd.flush_step = 1'b1;
					if (sts.flush_last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/xset_dp.sv
// Datapath: parse phase, position and depth counters, event planning,
// and the held-whitespace store. Depends on xset_pkg and xset_ram.
`default_nettype none
module xset_dp import xset_pkg::*; #(
	parameter int MAX_DEPTH     = 255,
	parameter int PENDING_SPACE = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        op,
	input  wire logic [7:0]  data_byte,
	input  wire dp_cmd_t     cmd,
	input  wire logic        in_flush,
	output dp_sts_t          sts,
	output logic [3:0]       event_res,
	output logic [7:0]       event_byte,
	output logic [2:0]       error_code,
	output logic [23:0]      line_number,
	output logic [15:0]      column_number,
	output logic [7:0]       nesting_depth
);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (PENDING_SPACE > 1) ? $clog2(PENDING_SPACE) : 1;
	localparam int CW = $clog2(PENDING_SPACE + 1);
	localparam int QW = $clog2(EVQ);

	phase_t          phase_q, ph_n;
	logic [DW-1:0]   depth_q, dep_n;
	logic [23:0]     line_q, line_n;
	logic [15:0]     col_q, col_n;
	logic            started_q, txt_q, txt_n;
	logic [CW-1:0]   pcnt_q, pcnt_n;
	logic [7:0]      byte_q;

	// planned events with the depth each one shows
	plan_ev_t        plan_q [EVQ];
	logic [DW-1:0]   pdep_q [EVQ];
	plan_ev_t        pl [EVQ];
	logic [DW-1:0]   pd [EVQ];
	logic [QW:0]     n_pl, cnt_q;
	logic [QW-1:0]   idx_q;
	logic            flush_q, fl_n;
	logic            flush_tail_q, ftail_n; // flushed run ends with the new byte
	logic [CW-1:0]   fidx_q, fcnt_q, fl_cnt;
	logic            wr_en;
	logic [AW-1:0]   raddr;
	logic [7:0]      rdata;
	logic [DW-1:0]   cur_dep;
	logic            d0, dmax;

	// end of input clears position, but its events show the old position
	logic [23:0]     line_prev_q;
	logic [15:0]     col_prev_q;
	logic            op_q;

	xset_ram #(.WIDTH(8), .DEPTH(PENDING_SPACE)) u_ram (
		.clk(clk), .we(wr_en && cmd.load), .waddr(pcnt_q[AW-1:0]), .wdata(data_byte),
		.raddr(raddr), .rdata(rdata)
	);

	function automatic logic is_q(input logic [7:0] c);
		return c == CH_APOS || c == CH_QUOT;
	endfunction

	// event planning for one accepted item
	always_comb begin
		logic [7:0] c;
		c       = data_byte;
		ph_n    = phase_q;
		dep_n   = depth_q;
		line_n  = line_q;
		col_n   = col_q;
		txt_n   = txt_q;
		pcnt_n  = pcnt_q;
		fl_n    = 1'b0;
		ftail_n = 1'b0;
		fl_cnt  = pcnt_q;
		wr_en   = 1'b0;
		n_pl    = '0;
		for (int i = 0; i < EVQ; i++) begin
			pl[i] = '{ev: EV_STARTDOC, use_byte: 1'b0, err: ERR_NONE};
			pd[i] = '0;
		end
		cur_dep = depth_q;
		d0   = depth_q == '0;
		dmax = depth_q == DW'(MAX_DEPTH);
		if (!started_q) begin
			pl[0] = '{EV_STARTDOC, 1'b0, ERR_NONE}; pd[0] = depth_q; n_pl = (QW+1)'(1);
		end
		if (op) begin
			if (phase_q != PH_DONE) begin
				pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b0, ERR_PREMATURE};
				pd[n_pl[QW-1:0]] = depth_q;
				pl[n_pl[QW-1:0] + 1'b1] = '{EV_ENDDOC, 1'b0, ERR_NONE};
				pd[n_pl[QW-1:0] + 1'b1] = depth_q;
				n_pl = n_pl + 2'd2;
			end
		end else if (phase_q != PH_DONE) begin
			if (c == CH_LF) begin
				if (line_q != 24'hFFFFFF) line_n = line_q + 24'd1;
				col_n = '0;
			end else if (col_q != 16'hFFFF) begin
				col_n = col_q + 16'd1;
			end
			// the cases below push events in order through this slot index
			unique case (phase_q)
				PH_SKIP, PH_DOC: begin
					if (phase_q == PH_DOC || !is_ws(c)) begin
						if (c == CH_LT) ph_n = PH_DOC_LT;
						else begin
							ph_n = PH_DOC;
							pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_BAD_START};
							pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
						end
					end
				end
				PH_DOC_LT: begin
					if (c == CH_QM) ph_n = PH_PI;
					else if (c == CH_EXCL) ph_n = PH_CMT;
					else begin
						ph_n = PH_STAG;
						pl[n_pl[QW-1:0]] = '{EV_NAME_BYTE, 1'b1, ERR_NONE};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end
				end
				PH_PI: begin
					if (c == CH_QM) ph_n = PH_PI_Q;
					else begin
						pl[n_pl[QW-1:0]] = '{EV_PI_BYTE, 1'b1, ERR_NONE};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end
				end
				PH_PI_Q: begin
					if (c != CH_GT) begin
						pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_BAD_PI_END};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end
					pl[n_pl[QW-1:0]] = '{EV_PI_END, 1'b0, ERR_NONE};
					pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					ph_n = PH_CONTENT;
				end
				PH_CMT: if (c == CH_DASH) ph_n = PH_CMT_D1;
				PH_CMT_D1: ph_n = (c == CH_DASH) ? PH_CMT_D2 : PH_CMT;
				PH_CMT_D2: ph_n = (c == CH_GT) ? PH_CONTENT : PH_CMT;
				PH_STAG, PH_STAG_WS, PH_CONTENT_LT: begin
					if (phase_q == PH_STAG_WS && is_ws(c)) begin
						ph_n = PH_STAG_WS;
					end else if (phase_q == PH_CONTENT_LT && c == CH_SLASH) begin
						ph_n = PH_ETAG;
					end else if (phase_q == PH_CONTENT_LT && c == CH_EXCL) begin
						ph_n = PH_CMT;
					end else if (c == CH_SLASH) begin
						ph_n = PH_STAG_SL;
					end else if (c == CH_GT) begin
						ph_n = PH_CONTENT;
						if (!dmax) cur_dep = depth_q + 1'b1;
						pl[n_pl[QW-1:0]] = '{EV_START_ELEM, 1'b0, ERR_NONE};
						pd[n_pl[QW-1:0]] = cur_dep; n_pl = n_pl + 1'b1;
						if (dmax) begin
							pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_OVERFLOW};
							pd[n_pl[QW-1:0]] = cur_dep; n_pl = n_pl + 1'b1;
						end
						dep_n = cur_dep;
					end else if (phase_q == PH_STAG_WS) begin
						ph_n = PH_ANAME;
						pl[n_pl[QW-1:0]] = '{EV_ATTR_NAME, 1'b1, ERR_NONE};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end else if (is_ws(c)) begin
						ph_n = PH_STAG_WS;
					end else begin
						ph_n = PH_STAG;
						pl[n_pl[QW-1:0]] = '{EV_NAME_BYTE, 1'b1, ERR_NONE};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end
				end
				PH_STAG_SL: begin
					// self-closing: open then close; worst case is bad end, open,
					// overflow, close and enddoc (MAX_DEPTH of 1), startdoc never owed
					if (c != CH_GT) begin
						pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_BAD_ELEM_END};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end
					ph_n = PH_CONTENT;
					if (!dmax) cur_dep = depth_q + 1'b1;
					pl[n_pl[QW-1:0]] = '{EV_START_ELEM, 1'b0, ERR_NONE};
					pd[n_pl[QW-1:0]] = cur_dep; n_pl = n_pl + 1'b1;
					if (dmax) begin
						pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_OVERFLOW};
						pd[n_pl[QW-1:0]] = cur_dep; n_pl = n_pl + 1'b1;
					end
					// cur_dep is nonzero after open since MAX_DEPTH is at least 1
					cur_dep = cur_dep - 1'b1;
					pl[n_pl[QW-1:0]] = '{EV_END_ELEM, 1'b0, ERR_NONE};
					pd[n_pl[QW-1:0]] = cur_dep; n_pl = n_pl + 1'b1;
					if (cur_dep == '0) begin
						pl[n_pl[QW-1:0]] = '{EV_ENDDOC, 1'b0, ERR_NONE};
						pd[n_pl[QW-1:0]] = cur_dep; n_pl = n_pl + 1'b1;
						ph_n = PH_DONE;
					end
					dep_n = cur_dep;
				end
				PH_ANAME: begin
					if (c == CH_EQ) ph_n = PH_AEQ;
					else if (!is_ws(c)) begin
						pl[n_pl[QW-1:0]] = '{EV_ATTR_NAME, 1'b1, ERR_NONE};
						pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
					end
				end
				PH_AEQ: begin
					if (!is_ws(c)) begin
						if (!is_q(c)) begin
							pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_BAD_QUOTE};
							pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
						end
						ph_n = PH_AVAL;
					end
				end
				PH_AVAL: begin
					if (is_q(c)) begin
						pl[n_pl[QW-1:0]] = '{EV_ATTR_END, 1'b0, ERR_NONE};
						ph_n = PH_STAG;
					end else begin
						pl[n_pl[QW-1:0]] = '{EV_ATTR_VALUE, 1'b1, ERR_NONE};
					end
					pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
				end
				PH_CONTENT: begin
					if (c == CH_LT) begin
						if (txt_q) begin
							pl[n_pl[QW-1:0]] = '{EV_TEXT_END, 1'b0, ERR_NONE};
							pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
						end
						txt_n  = 1'b0;
						pcnt_n = '0;
						ph_n   = PH_CONTENT_LT;
					end else if (is_ws(c)) begin
						if (txt_q) begin
							if (pcnt_q != CW'(PENDING_SPACE)) begin
								wr_en  = 1'b1;
								pcnt_n = pcnt_q + 1'b1;
							end else begin
								fl_n    = 1'b1;
								ftail_n = 1'b1;
								pcnt_n  = '0;
							end
						end
					end else begin
						fl_n    = 1'b1;
						ftail_n = 1'b1;
						pcnt_n  = '0;
						txt_n   = 1'b1;
					end
				end
				PH_ETAG: begin
					if (c == CH_GT) begin
						ph_n = PH_CONTENT;
						pl[n_pl[QW-1:0]] = '{EV_END_ELEM, 1'b0, ERR_NONE};
						if (d0) begin
							pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
							pl[n_pl[QW-1:0]] = '{EV_ERROR, 1'b1, ERR_UNDERFLOW};
							pd[n_pl[QW-1:0]] = depth_q; n_pl = n_pl + 1'b1;
						end else begin
							dep_n = depth_q - 1'b1;
							pd[n_pl[QW-1:0]] = dep_n; n_pl = n_pl + 1'b1;
							if (dep_n == '0) begin
								pl[n_pl[QW-1:0]] = '{EV_ENDDOC, 1'b0, ERR_NONE};
								pd[n_pl[QW-1:0]] = dep_n; n_pl = n_pl + 1'b1;
								ph_n = PH_DONE;
							end
						end
					end
				end
				default: ph_n = PH_DONE;
			endcase
		end
	end

	// flush runs the held entries then the new byte itself
	assign raddr = fidx_q[AW-1:0] + ((cmd.flush_step) ? AW'(1) : AW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			depth_q   <= '0;
			line_q    <= 24'd1;
			col_q     <= '0;
			started_q <= 1'b0;
			txt_q     <= 1'b0;
			pcnt_q    <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			flush_q   <= 1'b0;
			flush_tail_q <= 1'b0;
			fidx_q    <= '0;
			fcnt_q    <= '0;
		end else if (cmd.load) begin
			idx_q  <= '0;
			cnt_q  <= n_pl;
			flush_q <= fl_n;
			flush_tail_q <= ftail_n;
			fidx_q <= '0;
			fcnt_q <= fl_cnt;
			if (op) begin
				phase_q   <= PH_SKIP;
				depth_q   <= '0;
				line_q    <= 24'd1;
				col_q     <= '0;
				started_q <= 1'b0;
				txt_q     <= 1'b0;
				pcnt_q    <= '0;
			end else begin
				phase_q   <= ph_n;
				depth_q   <= dep_n;
				line_q    <= line_n;
				col_q     <= col_n;
				started_q <= 1'b1;
				txt_q     <= txt_n;
				pcnt_q    <= pcnt_n;
			end
		end else if (cmd.advance) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.flush_step) begin
			fidx_q <= fidx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
			for (int i = 0; i < EVQ; i++) begin
				plan_q[i] <= pl[i];
				pdep_q[i] <= pd[i];
			end
		end
	end

	logic flush_on_byte;
	assign flush_on_byte = fidx_q == fcnt_q;

	always_comb begin
		sts.has_plan   = cnt_q != '0;
		sts.plan_last  = cnt_q == (QW+1)'(1);
		sts.flush_req  = flush_q;
		sts.flush_last = flush_on_byte && flush_tail_q;
		if (in_flush) begin
			event_res     = EV_TEXT_BYTE;
			event_byte    = flush_on_byte ? byte_q : rdata;
			error_code    = ERR_NONE;
			nesting_depth = 8'(depth_q);
		end else begin
			event_res     = plan_q[idx_q].ev;
			event_byte    = plan_q[idx_q].use_byte ? byte_q : 8'd0;
			error_code    = plan_q[idx_q].err;
			nesting_depth = 8'(pdep_q[idx_q]);
		end
		// positions of startdoc on the first byte still read line 1 column 0
		if (!in_flush && plan_q[idx_q].ev == EV_STARTDOC) begin
			line_number   = 24'd1;
			column_number = 16'd0;
		end else if (!in_flush && plan_q[idx_q].err == ERR_PREMATURE) begin
			line_number   = line_prev_q;
			column_number = col_prev_q;
		end else if (!in_flush && plan_q[idx_q].ev == EV_ENDDOC && op_q) begin
			line_number   = line_prev_q;
			column_number = col_prev_q;
		end else begin
			line_number   = line_q;
			column_number = col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_prev_q <= line_q;
			col_prev_q  <= col_q;
			op_q        <= op;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/xml_sax_event_tokenizer.sv
// XML SAX tokenizer top level: ties the controller and the datapath.
// Depends on xset_pkg, xset_ctl, xset_dp.
//
// One byte (or end-of-input mark) is taken per item; it is decoded in the
// accept cycle into up to five planned events (five only when MAX_DEPTH is 1),
// which then leave one per cycle while the receiver is ready. An item with
// no events passes through the accept and emit states before the next.
// A text byte that releases held whitespace bytes goes through accept,
// an empty emit state, then the held run from a small RAM (one entry a
// cycle, registered read) and the byte itself. Receiver stalls hold the
// output. The next item is not taken until the last event of the current
// one has left, so item rate is set by the one-event-per-cycle sequencer.
`default_nettype none
module xml_sax_event_tokenizer import xset_pkg::*; #(
	parameter int MAX_DEPTH     = 255,
	parameter int PENDING_SPACE = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       event_res,
	output logic [7:0]       event_byte,
	output logic [2:0]       error_code,
	output logic [23:0]      line_number,
	output logic [15:0]      column_number,
	output logic [7:0]       nesting_depth,
	output logic             last
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_flush;

	assign in_flush = out_valid && !sts.has_plan;

	xset_ctl u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_last(last),
		.cmd(cmd), .sts(sts)
	);

	xset_dp #(.MAX_DEPTH(MAX_DEPTH), .PENDING_SPACE(PENDING_SPACE)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .data_byte(data_byte),
		.cmd(cmd), .in_flush(in_flush), .sts(sts),
		.event_res(event_res), .event_byte(event_byte), .error_code(error_code),
		.line_number(line_number), .column_number(column_number),
		.nesting_depth(nesting_depth)
	);
endmodule
`default_nettype wire

// File: hw/rtl/xset_chk.sv
// Port-level checker for the tokenizer and its bind.
// Depends on xset_pkg.
`default_nettype none
module xset_chk import xset_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] event_res,
	input wire logic [2:0] error_code,
	input wire logic [23:0] line_number
);
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_ERROR |-> error_code == ERR_NONE) else $error("code");
	a_err_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_ERROR |-> error_code != ERR_NONE) else $error("err");
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 24'd0) else $error("line");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res)) else $error("stall");
	// a new item is only taken once every event of the previous one has left
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("excl");
endmodule

bind xml_sax_event_tokenizer xset_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
	.error_code(error_code), .line_number(line_number)
);
`default_nettype wire
